// ----- rtl/core/hfcurv_pkg.sv -----
// ----------------------------------------------------------------------------
// hfcurv_pkg
// Shared types, widths and rounding helpers of the height-function curvature
// unit.
// ----------------------------------------------------------------------------
package hfcurv_pkg;

  localparam int FRAC_BITS = 16;
  localparam int Q_W       = 32;
  localparam int SP_W      = 31;

  // divider: numerator magnitude, divisor and quotient widths
  localparam int DIV_MW  = 34;
  localparam int DIV_DW  = 32;
  localparam int DIV_QW  = 32;
  localparam int DIV_XW  = DIV_MW + FRAC_BITS + 1;
  localparam int DIV_LAT = DIV_QW + 2;

  // square root: radicand width and one result bit per stage
  localparam int SQ_W     = 64;
  localparam int SQ_STEPS = SQ_W / 2;
  localparam int SQ_LAT   = SQ_STEPS + 3;

  localparam logic signed [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
  localparam logic signed [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};
  localparam logic [63:0] LIM_POS = 64'(Q_MAX);
  localparam logic [63:0] LIM_NEG = 64'(LIM_POS) + 64'd1;

  typedef struct packed {
    logic signed [Q_W-1:0]  height_first_minus;
    logic signed [Q_W-1:0]  height_center;
    logic signed [Q_W-1:0]  height_first_plus;
    logic signed [Q_W-1:0]  height_second_minus;
    logic signed [Q_W-1:0]  height_second_plus;
    logic        [SP_W-1:0] space_first_minus;
    logic        [SP_W-1:0] space_first_plus;
    logic        [SP_W-1:0] space_second_minus;
    logic        [SP_W-1:0] space_second_plus;
    logic                   first_dir_valid;
    logic                   second_dir_valid;
    logic        [SP_W-1:0] radial_center;
  } in_item_t;

  typedef struct packed {
    logic signed [Q_W-1:0] curvature;
    logic                  saturated;
  } out_item_t;

  typedef struct packed {
    logic                  flag;
    logic signed [Q_W-1:0] val;
  } sat_t;

  // Apply a sign to a magnitude and clamp to the word limits.
  function automatic sat_t from_mag(input logic [63:0] m, input logic neg);
    sat_t r;
    r.flag = 1'b0;
    if (neg) begin
      if (m > LIM_NEG) begin
        r.flag = 1'b1;
        r.val  = Q_MIN;
      end else begin
        r.val = Q_W'(64'd0 - m);
      end
    end else begin
      if (m > LIM_POS) begin
        r.flag = 1'b1;
        r.val  = Q_MAX;
      end else begin
        r.val = Q_W'(m);
      end
    end
    return r;
  endfunction

  // Round a registered product back to the fixed-point format.
  function automatic sat_t rnd_prod(input logic signed [63:0] p, input logic neg);
    logic [63:0] m;
    logic [63:0] q;
    m = p[63] ? 64'd0 - 64'(p) : 64'(p);
    q = (m + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    return from_mag(q, p[63] ^ neg);
  endfunction

endpackage

// ----- rtl/core/hfcurv_div.sv -----
// ----------------------------------------------------------------------------
// hfcurv_div
// Pipelined rounding divider: round(m * 2^FRAC_BITS / den), signed, clamped.
// One quotient bit per stage.
// ----------------------------------------------------------------------------
module hfcurv_div (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [hfcurv_pkg::DIV_MW-1:0] m_i,
  input  logic                          neg_i,
  input  logic [hfcurv_pkg::DIV_DW-1:0] den_i,
  output hfcurv_pkg::sat_t              q_o
);

  typedef struct packed {
    logic [hfcurv_pkg::DIV_DW-1:0] rem;
    logic [hfcurv_pkg::DIV_DW-1:0] den;
    logic [hfcurv_pkg::DIV_QW-1:0] xq;
    logic                          neg;
    logic                          ovf;
    logic                          zero;
    logic                          mzero;
  } div_st_t;

  div_st_t st_q [hfcurv_pkg::DIV_QW+1];
  div_st_t st_d [hfcurv_pkg::DIV_QW+1];
  logic [hfcurv_pkg::DIV_XW-1:0] x;
  hfcurv_pkg::sat_t              res;

  // Form the rounded dividend, then run the restoring steps
  always_comb begin
    logic [hfcurv_pkg::DIV_DW:0] t;
    logic                        b;
    // detect a quotient too wide for the word
    x = hfcurv_pkg::DIV_XW'({m_i, {hfcurv_pkg::FRAC_BITS{1'b0}}})
      + hfcurv_pkg::DIV_XW'(den_i[hfcurv_pkg::DIV_DW-1:1]);
    st_d[0].rem   = hfcurv_pkg::DIV_DW'(x[hfcurv_pkg::DIV_XW-1:hfcurv_pkg::DIV_QW]);
    st_d[0].den   = den_i;
    st_d[0].xq    = x[hfcurv_pkg::DIV_QW-1:0];
    st_d[0].neg   = neg_i;
    st_d[0].ovf   = 64'(x[hfcurv_pkg::DIV_XW-1:hfcurv_pkg::DIV_QW]) >= 64'(den_i);
    st_d[0].zero  = (den_i == '0);
    st_d[0].mzero = (m_i == '0);
    // shift one dividend bit in, one quotient bit out
    for (int k = 1; k <= hfcurv_pkg::DIV_QW; k++) begin
      t = {st_q[k-1].rem, st_q[k-1].xq[hfcurv_pkg::DIV_QW-1]};
      st_d[k] = st_q[k-1];
      if (t >= {1'b0, st_q[k-1].den}) begin
        st_d[k].rem = hfcurv_pkg::DIV_DW'(t - {1'b0, st_q[k-1].den});
        b = 1'b1;
      end else begin
        st_d[k].rem = t[hfcurv_pkg::DIV_DW-1:0];
        b = 1'b0;
      end
      st_d[k].xq = {st_q[k-1].xq[hfcurv_pkg::DIV_QW-2:0], b};
    end
  end

  // Clamp on zero divisor or overflow, else sign the quotient
  always_comb begin
    if (st_q[hfcurv_pkg::DIV_QW].zero) begin
      res.flag = 1'b1;
      res.val  = st_q[hfcurv_pkg::DIV_QW].mzero ? '0 :
                 (st_q[hfcurv_pkg::DIV_QW].neg ? hfcurv_pkg::Q_MIN : hfcurv_pkg::Q_MAX);
    end else if (st_q[hfcurv_pkg::DIV_QW].ovf) begin
      res.flag = 1'b1;
      res.val  = st_q[hfcurv_pkg::DIV_QW].neg ? hfcurv_pkg::Q_MIN : hfcurv_pkg::Q_MAX;
    end else begin
      res = hfcurv_pkg::from_mag(64'(st_q[hfcurv_pkg::DIV_QW].xq),
                                 st_q[hfcurv_pkg::DIV_QW].neg);
    end
  end

  // Advance all stages together
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k <= hfcurv_pkg::DIV_QW; k++) begin
        st_q[k] <= st_d[k];
      end
      q_o <= res;
    end
  end

endmodule

// ----- rtl/core/axisymmetric_height_function_curvature_unit.sv -----
// Throughput: one item per cycle while the output is not stalled; the chained pipelined
// dividers, the 32-stage square root and the four multiply-and-round steps set the latency.
// A stall at the output freezes the whole pipeline in place while an item is held there.
// Reset clears every valid bit and sets the gain register to 1.0.
// ----------------------------------------------------------------------------
// axisymmetric_height_function_curvature_unit
// Per-cell curvature from five stencil heights on a non-uniform grid:
// Cartesian term h''/(1+h'^2)^1.5 plus an axisymmetric term, scaled by -gain.
// ----------------------------------------------------------------------------
module axisymmetric_height_function_curvature_unit (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  hfcurv_pkg::in_item_t   in_item_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output hfcurv_pkg::out_item_t  out_item_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [hfcurv_pkg::Q_W-1:0] cfg_data_i
);

  localparam int QW = hfcurv_pkg::Q_W;
  localparam int SW = hfcurv_pkg::SP_W;
  localparam int MW = hfcurv_pkg::DIV_MW;
  localparam int DW = hfcurv_pkg::DIV_DW;
  localparam int DL = hfcurv_pkg::DIV_LAT;
  localparam int SL = hfcurv_pkg::SQ_LAT;
  localparam int NS = hfcurv_pkg::SQ_STEPS;
  localparam int XW = hfcurv_pkg::SQ_W;

  typedef struct packed {
    logic valid;
    logic signed [QW-1:0] hm, hc, hp;
    logic [SW-1:0] dm, dp, rad;
    logic first, dir;
  } p0_t;

  typedef struct packed {
    logic valid;
    logic [DW-1:0] dsum;
    logic [SW-1:0] rad;
    logic first, dir;
  } ph1_t;

  typedef struct packed {
    logic valid;
    logic signed [QW-1:0] s_c, s_u, s_d;
    logic [DW-1:0] dsum;
    logic [SW-1:0] rad;
    logic first, dir, flag;
  } p1_t;

  typedef struct packed {
    logic valid;
    logic signed [QW-1:0] s_u, s_d;
    logic [SW-1:0] rad;
    logic first, dir, flag;
  } ph2_t;

  typedef struct packed {
    logic valid;
    logic signed [QW-1:0] s_2, s_u, s_d;
    logic [QW-1:0] rc, ru, rd;
    logic [SW-1:0] rad;
    logic first, flag;
  } p2_t;

  typedef struct packed {
    logic valid;
    logic signed [QW-1:0] s_2;
    logic [SW-1:0] rad;
    logic first, flag;
  } ph3_t;

  typedef struct packed {
    logic valid;
    logic signed [QW-1:0] w;
    logic signed [QW:0] sum;
    logic signed [QW-1:0] s_2;
    logic [SW-1:0] rad;
    logic first, flag;
  } p3_t;

  typedef struct packed {
    logic valid;
    logic signed [QW-1:0] s_2, w;
    logic flag;
  } ph4_t;

  typedef struct packed {
    logic valid;
    logic signed [QW-1:0] s_2, w, cyl;
    logic flag;
  } p4_t;

  typedef struct packed {
    logic valid;
    logic signed [QW-1:0] w, cylg;
    logic flag;
  } c5_t;

  function automatic logic [MW-1:0] mag_of(input logic signed [MW-1:0] v);
    logic [MW-1:0] r;
    r = v[MW-1] ? MW'(-v) : MW'(v);
    return r;
  endfunction

  logic en;
  logic signed [QW-1:0] gain_q;

  p0_t  p0_q, p0_d;
  ph1_t l1_q [DL];
  ph1_t l1_d;
  p1_t  p1_q, p1_d;
  ph2_t l2_q [SL];
  ph2_t l2_d;
  p2_t  p2_q, p2_d;
  ph3_t l3_q [DL];
  ph3_t l3_d;
  p3_t  p3_q, p3_d;
  ph4_t l4_q [DL];
  ph4_t l4_d;
  p4_t  p4_q, p4_d;

  hfcurv_pkg::sat_t qa, qb, qc, qd, qw, qu, qv, qy;
  hfcurv_pkg::sat_t dq_q;

  logic signed [QW:0]   na, nb, nc;
  logic signed [MW-1:0] nd;
  logic [DW-1:0]        dsum;
  logic [MW-1:0]        ym;
  logic                 yneg;
  logic [DW-1:0]        yden;

  logic [QW-1:0] sqm   [3];
  logic [XW-1:0] sp_q  [3];
  logic [XW-1:0] sx_q  [3][NS+1];
  logic [XW-1:0] sr_q  [3][NS+1];
  logic [XW-1:0] sx_d  [3][NS+1];
  logic [XW-1:0] sr_d  [3][NS+1];
  logic [QW-1:0] rt_q  [3];

  logic signed [63:0]   mp_q [4];
  logic signed [63:0]   mp_d [4];
  logic signed [63:0]   pg_q;
  hfcurv_pkg::sat_t     rr_q [4];
  hfcurv_pkg::sat_t     rs   [4];
  hfcurv_pkg::sat_t     cs;
  c5_t                  mc_q [4];
  c5_t                  mc_d [4];
  c5_t                  rc_q [4];
  c5_t                  rc_d [4];

  logic signed [QW:0]    tot;
  hfcurv_pkg::out_item_t out_d, out_q;
  logic                  out_valid_q;

  // Freeze the pipeline while the output holds an item that is stalled
  assign en          = !(out_valid_q && out_stall_i);
  assign in_stall_o  = !en;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Hold the gain register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= QW'(32'sd65536);
    end else if (cfg_valid_i && cfg_ready_o) begin
      gain_q <= cfg_data_i;
    end
  end

  // Select the height triple and spacings by major direction
  always_comb begin
    p0_d.valid = in_valid_i;
    p0_d.first = in_item_i.first_dir_valid;
    p0_d.dir   = in_item_i.first_dir_valid | in_item_i.second_dir_valid;
    p0_d.hc    = in_item_i.height_center;
    p0_d.rad   = in_item_i.radial_center;
    if (in_item_i.first_dir_valid) begin
      p0_d.hm = in_item_i.height_first_minus;
      p0_d.hp = in_item_i.height_first_plus;
      p0_d.dm = in_item_i.space_first_minus;
      p0_d.dp = in_item_i.space_first_plus;
    end else begin
      p0_d.hm = in_item_i.height_second_minus;
      p0_d.hp = in_item_i.height_second_plus;
      p0_d.dm = in_item_i.space_second_minus;
      p0_d.dp = in_item_i.space_second_plus;
    end
  end

  // Height differences and spacing sum for the slope divisions
  assign na   = (QW+1)'(p0_q.hp) - (QW+1)'(p0_q.hm);
  assign nb   = (QW+1)'(p0_q.hp) - (QW+1)'(p0_q.hc);
  assign nc   = (QW+1)'(p0_q.hc) - (QW+1)'(p0_q.hm);
  assign dsum = DW'(p0_q.dm) + DW'(p0_q.dp);

  hfcurv_div u_div_c (
    .clk_i (clk_i), .en_i (en), .m_i (mag_of(MW'(na))), .neg_i (na[QW]),
    .den_i (dsum), .q_o (qa)
  );
  hfcurv_div u_div_u (
    .clk_i (clk_i), .en_i (en), .m_i (mag_of(MW'(nb))), .neg_i (nb[QW]),
    .den_i (DW'(p0_q.dp)), .q_o (qb)
  );
  hfcurv_div u_div_d (
    .clk_i (clk_i), .en_i (en), .m_i (mag_of(MW'(nc))), .neg_i (nc[QW]),
    .den_i (DW'(p0_q.dm)), .q_o (qc)
  );

  always_comb begin
    l1_d.valid = p0_q.valid;
    l1_d.dsum  = dsum;
    l1_d.rad   = p0_q.rad;
    l1_d.first = p0_q.first;
    l1_d.dir   = p0_q.dir;
  end

  // Gate the slopes by the direction flags
  always_comb begin
    p1_d.valid = l1_q[DL-1].valid;
    p1_d.dsum  = l1_q[DL-1].dsum;
    p1_d.rad   = l1_q[DL-1].rad;
    p1_d.first = l1_q[DL-1].first;
    p1_d.dir   = l1_q[DL-1].dir;
    p1_d.s_c   = l1_q[DL-1].dir ? qa.val : '0;
    p1_d.s_u   = l1_q[DL-1].dir ? qb.val : '0;
    p1_d.s_d   = l1_q[DL-1].dir ? qc.val : '0;
    p1_d.flag  = l1_q[DL-1].dir & (qa.flag | qb.flag | qc.flag);
  end

  // Second derivative from the one-sided slopes
  assign nd = MW'((QW+1)'(p1_q.s_u) - (QW+1)'(p1_q.s_d)) <<< 1;

  hfcurv_div u_div_2 (
    .clk_i (clk_i), .en_i (en), .m_i (mag_of(nd)), .neg_i (nd[MW-1]),
    .den_i (p1_q.dsum), .q_o (qd)
  );

  // Root of 1 + s^2 in three lanes, one result bit per stage
  assign sqm[0] = p1_q.s_c[QW-1] ? QW'(-p1_q.s_c) : QW'(p1_q.s_c);
  assign sqm[1] = p1_q.s_u[QW-1] ? QW'(-p1_q.s_u) : QW'(p1_q.s_u);
  assign sqm[2] = p1_q.s_d[QW-1] ? QW'(-p1_q.s_d) : QW'(p1_q.s_d);

  always_comb begin
    logic [XW-1:0] bt;
    logic [XW-1:0] tr;
    for (int l = 0; l < 3; l++) begin
      sx_d[l][0] = sp_q[l] + (XW'(1) << (2 * hfcurv_pkg::FRAC_BITS));
      sr_d[l][0] = '0;
      for (int k = 1; k <= NS; k++) begin
        bt = XW'(1) << (XW - 2 * k);
        tr = sr_q[l][k-1] + bt;
        if (sx_q[l][k-1] >= tr) begin
          sx_d[l][k] = sx_q[l][k-1] - tr;
          sr_d[l][k] = (sr_q[l][k-1] >> 1) + bt;
        end else begin
          sx_d[l][k] = sx_q[l][k-1];
          sr_d[l][k] = sr_q[l][k-1] >> 1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        sp_q[l] <= XW'(sqm[l]) * XW'(sqm[l]);
        for (int k = 0; k <= NS; k++) begin
          sx_q[l][k] <= sx_d[l][k];
          sr_q[l][k] <= sr_d[l][k];
        end
        rt_q[l] <= QW'(sr_q[l][NS] + XW'(sx_q[l][NS] > sr_q[l][NS]));
      end
      dq_q <= qd;
    end
  end

  always_comb begin
    l2_d.valid = p1_q.valid;
    l2_d.s_u   = p1_q.s_u;
    l2_d.s_d   = p1_q.s_d;
    l2_d.rad   = p1_q.rad;
    l2_d.first = p1_q.first;
    l2_d.dir   = p1_q.dir;
    l2_d.flag  = p1_q.flag;
  end

  always_comb begin
    p2_d.valid = l2_q[SL-1].valid;
    p2_d.s_2   = l2_q[SL-1].dir ? dq_q.val : '0;
    p2_d.s_u   = l2_q[SL-1].s_u;
    p2_d.s_d   = l2_q[SL-1].s_d;
    p2_d.rc    = rt_q[0];
    p2_d.ru    = rt_q[1];
    p2_d.rd    = rt_q[2];
    p2_d.rad   = l2_q[SL-1].rad;
    p2_d.first = l2_q[SL-1].first;
    p2_d.flag  = l2_q[SL-1].flag | (l2_q[SL-1].dir & dq_q.flag);
  end

  // Reciprocal root and the two slope terms
  hfcurv_div u_div_w (
    .clk_i (clk_i), .en_i (en), .m_i (MW'(1) << hfcurv_pkg::FRAC_BITS), .neg_i (1'b0),
    .den_i (p2_q.rc), .q_o (qw)
  );
  hfcurv_div u_div_tu (
    .clk_i (clk_i), .en_i (en), .m_i (mag_of(MW'(p2_q.s_u))), .neg_i (p2_q.s_u[QW-1]),
    .den_i (p2_q.ru), .q_o (qu)
  );
  hfcurv_div u_div_td (
    .clk_i (clk_i), .en_i (en), .m_i (mag_of(MW'(p2_q.s_d))), .neg_i (p2_q.s_d[QW-1]),
    .den_i (p2_q.rd), .q_o (qv)
  );

  always_comb begin
    l3_d.valid = p2_q.valid;
    l3_d.s_2   = p2_q.s_2;
    l3_d.rad   = p2_q.rad;
    l3_d.first = p2_q.first;
    l3_d.flag  = p2_q.flag;
  end

  always_comb begin
    p3_d.valid = l3_q[DL-1].valid;
    p3_d.w     = qw.val;
    p3_d.sum   = (QW+1)'(qu.val) + (QW+1)'(qv.val);
    p3_d.s_2   = l3_q[DL-1].s_2;
    p3_d.rad   = l3_q[DL-1].rad;
    p3_d.first = l3_q[DL-1].first;
    p3_d.flag  = l3_q[DL-1].flag | qw.flag | (l3_q[DL-1].first & (qu.flag | qv.flag));
  end

  // Axisymmetric term: summed slope terms over 2r, or -w over r
  always_comb begin
    if (p3_q.first) begin
      ym   = mag_of(MW'(p3_q.sum));
      yneg = p3_q.sum[QW];
      yden = {p3_q.rad, 1'b0};
    end else begin
      ym   = mag_of(MW'(p3_q.w));
      yneg = (p3_q.w > 0);
      yden = DW'(p3_q.rad);
    end
  end

  hfcurv_div u_div_y (
    .clk_i (clk_i), .en_i (en), .m_i (ym), .neg_i (yneg), .den_i (yden), .q_o (qy)
  );

  always_comb begin
    l4_d.valid = p3_q.valid;
    l4_d.s_2   = p3_q.s_2;
    l4_d.w     = p3_q.w;
    l4_d.flag  = p3_q.flag;
  end

  always_comb begin
    p4_d.valid = l4_q[DL-1].valid;
    p4_d.s_2   = l4_q[DL-1].s_2;
    p4_d.w     = l4_q[DL-1].w;
    p4_d.cyl   = qy.val;
    p4_d.flag  = l4_q[DL-1].flag | qy.flag;
  end

  // Cartesian term h''*w*w*w, then both terms times -gain
  always_comb begin
    mc_d[0].valid = p4_q.valid;
    mc_d[0].w     = p4_q.w;
    mc_d[0].cylg  = '0;
    mc_d[0].flag  = p4_q.flag;
    mp_d[0]       = 64'(p4_q.s_2) * 64'(p4_q.w);
    for (int k = 1; k < 4; k++) begin
      mc_d[k] = rc_q[k-1];
      if (k == 3) begin
        mp_d[k] = 64'(rr_q[k-1].val) * 64'(gain_q);
      end else begin
        mp_d[k] = 64'(rr_q[k-1].val) * 64'(rc_q[k-1].w);
      end
    end
    cs = hfcurv_pkg::rnd_prod(pg_q, 1'b1);
    for (int k = 0; k < 4; k++) begin
      rs[k]        = hfcurv_pkg::rnd_prod(mp_q[k], k == 3);
      rc_d[k]      = mc_q[k];
      rc_d[k].flag = mc_q[k].flag | rs[k].flag;
    end
    rc_d[0].cylg = cs.val;
    rc_d[0].flag = mc_q[0].flag | rs[0].flag | cs.flag;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pg_q <= 64'(p4_q.cyl) * 64'(gain_q);
      for (int k = 0; k < 4; k++) begin
        mp_q[k] <= mp_d[k];
        rr_q[k] <= rs[k];
      end
    end
  end

  // Saturate the sum of both terms
  always_comb begin
    tot = (QW+1)'(rr_q[3].val) + (QW+1)'(rc_q[3].cylg);
    out_d.saturated = rc_q[3].flag;
    out_d.curvature = tot[QW-1:0];
    if (tot[QW] != tot[QW-1]) begin
      out_d.saturated = 1'b1;
      out_d.curvature = tot[QW] ? hfcurv_pkg::Q_MIN : hfcurv_pkg::Q_MAX;
    end
  end

  // Advance stage registers and delay lines; valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p0_q        <= '0;
      p1_q        <= '0;
      p2_q        <= '0;
      p3_q        <= '0;
      p4_q        <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      for (int k = 0; k < DL; k++) begin
        l1_q[k] <= '0;
        l3_q[k] <= '0;
        l4_q[k] <= '0;
      end
      for (int k = 0; k < SL; k++) begin
        l2_q[k] <= '0;
      end
      for (int k = 0; k < 4; k++) begin
        mc_q[k] <= '0;
        rc_q[k] <= '0;
      end
    end else if (en) begin
      p0_q <= p0_d;
      p1_q <= p1_d;
      p2_q <= p2_d;
      p3_q <= p3_d;
      p4_q <= p4_d;
      l1_q[0] <= l1_d;
      l3_q[0] <= l3_d;
      l4_q[0] <= l4_d;
      for (int k = 1; k < DL; k++) begin
        l1_q[k] <= l1_q[k-1];
        l3_q[k] <= l3_q[k-1];
        l4_q[k] <= l4_q[k-1];
      end
      l2_q[0] <= l2_d;
      for (int k = 1; k < SL; k++) begin
        l2_q[k] <= l2_q[k-1];
      end
      for (int k = 0; k < 4; k++) begin
        mc_q[k] <= mc_d[k];
        rc_q[k] <= rc_d[k];
      end
      out_valid_q <= rc_q[3].valid;
      out_q       <= out_d;
    end
  end

endmodule

// ----- tb/axisymmetric_height_function_curvature_unit_test.sv -----
// ----------------------------------------------------------------------------
// Curvature unit testbench
// Drives stencil items through the valid/stall input channel with random
// gaps, predicts each curvature result in fixed point, and compares every
// output item with the oldest prediction. The gain register is changed
// between phases while the pipeline is empty.
// ----------------------------------------------------------------------------
module axisymmetric_height_function_curvature_unit_test;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int PIPE_LAT  = 151;
  localparam int WDOG_MAX  = 20000;
  localparam int N_RANDOM  = 1500;
  localparam int N_PHASES  = 5;
  localparam int N_DIRECT  = 14;
  localparam int FB        = hfcurv_pkg::FRAC_BITS;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  hfcurv_pkg::in_item_t in_item_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  hfcurv_pkg::out_item_t out_item_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [hfcurv_pkg::Q_W-1:0] cfg_data_i = '0;

  always #5 clk_i = ~clk_i;

  axisymmetric_height_function_curvature_unit dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_item_i,
    .out_valid_o, .out_stall_i, .out_item_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  logic signed [31:0] gain_q = 32'sd65536;
  hfcurv_pkg::out_item_t expected_q[$];
  int errors = 0;
  int idle_cycles = 0;
  int stall_left = 0;
  bit stim_done = 1'b0;

  // Directed stimulus: item, and a typed-in result where it is obvious.
  typedef struct {
    hfcurv_pkg::in_item_t item;
    bit known;
    hfcurv_pkg::out_item_t res;
  } vec_t;
  vec_t directed[N_DIRECT];

  // ---- fixed-point arithmetic of the curvature path ----
  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    return v < 0 ? 64'd0 - 64'(v) : 64'(v);
  endfunction

  function automatic logic signed [63:0] clamp_mag(input logic [63:0] m, input bit neg,
                                                  inout logic f);
    if (neg) begin
      if (m > 64'd2147483648) begin
        f = 1'b1;
        return -64'sd2147483648;
      end
      return -$signed(m);
    end
    if (m > 64'd2147483647) begin
      f = 1'b1;
      return 64'sd2147483647;
    end
    return $signed(m);
  endfunction

  function automatic logic signed [63:0] qdiv(input logic signed [63:0] num,
                                             input logic [63:0] den, inout logic f);
    logic [63:0] m;
    logic [63:0] q;
    m = mag64(num);
    if (den == 0) begin
      f = 1'b1;
      return num > 0 ? 64'sd2147483647 : (num < 0 ? -64'sd2147483648 : 64'sd0);
    end
    q = ((m << FB) + den / 2) / den;
    return clamp_mag(q, num < 0, f);
  endfunction

  function automatic logic signed [63:0] qmul(input logic signed [63:0] a,
                                             input logic signed [63:0] b, input bit neg,
                                             inout logic f);
    logic signed [63:0] p;
    logic [63:0] q;
    p = a * b;
    q = (mag64(p) + (64'd1 << (FB - 1))) >> FB;
    return clamp_mag(q, (p < 0) != neg, f);
  endfunction

  function automatic logic [63:0] sqrt_nearest(input logic [63:0] x);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    if (x > r) r = r + 1;
    return r;
  endfunction

  function automatic logic [63:0] slope_root(input logic signed [63:0] s);
    logic [63:0] m;
    m = mag64(s);
    return sqrt_nearest(m * m + (64'd1 << (2 * FB)));
  endfunction

  // Predict one result item from a stencil item and the current gain.
  function automatic hfcurv_pkg::out_item_t predict_curvature(
      input hfcurv_pkg::in_item_t it, input logic signed [31:0] gain);
    logic f;
    bit first;
    bit dir;
    logic signed [63:0] hm, hc, hp, sc, su, sd, s2, w, cart, cyl, total, rt;
    logic [63:0] dm, dp, rad;
    hfcurv_pkg::out_item_t r;
    f = 1'b0;
    first = it.first_dir_valid;
    dir = first || it.second_dir_valid;
    sc = 0; su = 0; sd = 0; s2 = 0;
    if (first) begin
      hm = it.height_first_minus;
      hp = it.height_first_plus;
      dm = it.space_first_minus;
      dp = it.space_first_plus;
    end else begin
      hm = it.height_second_minus;
      hp = it.height_second_plus;
      dm = it.space_second_minus;
      dp = it.space_second_plus;
    end
    hc = it.height_center;
    rad = it.radial_center;
    if (dir) begin
      sc = qdiv(hp - hm, dm + dp, f);
      su = qdiv(hp - hc, dp, f);
      sd = qdiv(hc - hm, dm, f);
      s2 = qdiv(2 * (su - sd), dm + dp, f);
    end
    rt = $signed(slope_root(sc));
    w = ((64'sd1 << (2 * FB)) + rt / 2) / rt;
    cart = qmul(s2, w, 1'b0, f);
    cart = qmul(cart, w, 1'b0, f);
    cart = qmul(cart, w, 1'b0, f);
    if (first) begin
      rt = qdiv(su, slope_root(su), f) + qdiv(sd, slope_root(sd), f);
      cyl = qdiv(rt, 2 * rad, f);
    end else begin
      cyl = qdiv(-w, rad, f);
    end
    cart = qmul(cart, gain, 1'b1, f);
    cyl = qmul(cyl, gain, 1'b1, f);
    total = cart + cyl;
    if (total > 64'sd2147483647) begin
      f = 1'b1;
      total = 64'sd2147483647;
    end else if (total < -64'sd2147483648) begin
      f = 1'b1;
      total = -64'sd2147483648;
    end
    r.curvature = total[31:0];
    r.saturated = f;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    errors++;
    $display("mismatch %s: got %0d want %0d at %0t", what, $signed(got), $signed(want),
             $realtime);
  endtask

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic logic [30:0] rand_space();
    case ($urandom_range(0, 5))
      0: return 31'($urandom_range(1, 4));
      1: return 31'h7FFF_FFFF - 31'($urandom_range(0, 3));
      2: return 31'($urandom) | 31'd1;
      default: return 31'($urandom_range(16384, 262144));
    endcase
  endfunction

  function automatic logic [31:0] rand_height();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return 32'($signed($urandom_range(0, 1048576)) - 524288);
    endcase
  endfunction

  // Mostly well-scaled stencils, some raw bit patterns.
  function automatic hfcurv_pkg::in_item_t rand_item();
    hfcurv_pkg::in_item_t it;
    logic [319:0] raw;
    if ($urandom_range(0, 9) == 0) begin
      raw = {$urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom, $urandom, $urandom, $urandom};
      it = raw[$bits(hfcurv_pkg::in_item_t)-1:0];
    end else begin
      it.height_first_minus = rand_height();
      it.height_center = rand_height();
      it.height_first_plus = rand_height();
      it.height_second_minus = rand_height();
      it.height_second_plus = rand_height();
      it.space_first_minus = rand_space();
      it.space_first_plus = rand_space();
      it.space_second_minus = rand_space();
      it.space_second_plus = rand_space();
      it.first_dir_valid = 1'($urandom_range(0, 1));
      it.second_dir_valid = 1'($urandom_range(0, 1));
      it.radial_center = rand_space();
    end
    return it;
  endfunction

  function automatic hfcurv_pkg::in_item_t plain_item(input logic [31:0] hm,
                                                      input logic [31:0] hc,
                                                      input logic [31:0] hp, input bit f1,
                                                      input bit f2, input logic [30:0] sp,
                                                      input logic [30:0] rad);
    hfcurv_pkg::in_item_t it;
    it.height_first_minus = hm;
    it.height_center = hc;
    it.height_first_plus = hp;
    it.height_second_minus = hm;
    it.height_second_plus = hp;
    it.space_first_minus = sp;
    it.space_first_plus = sp;
    it.space_second_minus = sp;
    it.space_second_plus = sp;
    it.first_dir_valid = f1;
    it.second_dir_valid = f2;
    it.radial_center = rad;
    return it;
  endfunction

  // Hand one item over; hold it until accepted. Valid drops only for a gap.
  task automatic send_item(input hfcurv_pkg::in_item_t it);
    int gap;
    gap = gap_len();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_q.push_back(predict_curvature(it, gain_q));
  endtask

  task automatic write_gain(input logic [31:0] g);
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (PIPE_LAT + 4) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= g;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    gain_q = g;
  endtask

  // Output side: stall in random runs, compare accepted items.
  always @(posedge clk_i) begin
    hfcurv_pkg::out_item_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected item", out_item_o.curvature, 32'd0);
        end else begin
          want = expected_q.pop_front();
          if (out_item_o.curvature !== want.curvature)
            report_mismatch("curvature", out_item_o.curvature, want.curvature);
          if (out_item_o.saturated !== want.saturated)
            report_mismatch("saturated", 32'(out_item_o.saturated), 32'(want.saturated));
        end
      end
      if (stim_done) begin
        out_stall_i <= 1'b0;
        stall_left <= 0;
      end else if (stall_left != 0) begin
        out_stall_i <= 1'b1;
        stall_left <= stall_left - 1;
      end else begin
        out_stall_i <= 1'b0;
        stall_left <= ($urandom_range(0, 99) < 25) ? gap_len() : 0;
      end
    end
  end

  // Watchdog on accepted traffic.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)
        || (cfg_valid_i && cfg_ready_o))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_MAX) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    logic [31:0] gains[N_PHASES];
    hfcurv_pkg::out_item_t typed;
    gains = '{32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000,
              32'hFFFE_8000};
    // flat stencils, no flags, extremes, zero-free corner spacings
    directed[0] = '{plain_item(0, 0, 0, 1, 0, 31'h1_0000, 31'h1_0000), 1, '{0, 0}};
    directed[1] = '{plain_item(0, 0, 0, 0, 0, 31'h1_0000, 31'h1_0000), 1,
                    '{32'h0001_0000, 0}};
    directed[2] = '{plain_item(0, 0, 0, 0, 1, 31'h1_0000, 31'h1_0000), 1,
                    '{32'h0001_0000, 0}};
    directed[3] = '{plain_item(32'h8000_0000, 0, 32'h7FFF_FFFF, 1, 0, 1, 1), 0, '{0, 0}};
    directed[4] = '{plain_item(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1, 1,
                    31'h7FFF_FFFF, 1), 0, '{0, 0}};
    directed[5] = '{plain_item(32'h0001_0000, 0, 32'h0001_0000, 1, 0, 31'h1_0000,
                    31'h7FFF_FFFF), 0, '{0, 0}};
    directed[6] = '{plain_item(32'hFFFF_0000, 0, 32'h0001_0000, 0, 1, 31'h8000,
                    31'h1_0000), 0, '{0, 0}};
    directed[7] = '{plain_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 1, 1),
                    0, '{0, 0}};
    directed[8] = '{plain_item(0, 32'h0002_0000, 0, 1, 0, 31'h1_0000, 31'h2_0000), 0,
                    '{0, 0}};
    directed[9] = '{plain_item(0, 32'h0002_0000, 0, 0, 1, 31'h1_0000, 31'h2_0000), 0,
                    '{0, 0}};
    directed[10] = '{plain_item(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0, 1,
                     31'h7FFF_FFFF, 31'h7FFF_FFFF), 0, '{0, 0}};
    directed[11] = '{'1, 0, '{0, 0}};
    directed[12] = '{'0, 0, '{0, 0}};
    directed[13] = '{plain_item(32'h0000_8000, 32'h0000_4000, 32'h0001_0000, 1, 0, 2, 3),
                     0, '{0, 0}};
    directed[12].item.radial_center = 31'd1;
    directed[12].item.space_first_minus = 31'd1;
    directed[12].item.space_first_plus = 31'd1;
    directed[12].item.space_second_minus = 31'd1;
    directed[12].item.space_second_plus = 31'd1;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows at the reset gain.
    foreach (directed[i]) begin
      send_item(directed[i].item);
      if (directed[i].known) begin
        typed = directed[i].res;
        if (expected_q[$] !== typed)
          report_mismatch("typed row", expected_q[$].curvature, typed.curvature);
      end
    end

    // Random phases, one gain each.
    for (int p = 0; p < N_PHASES; p++) begin
      write_gain(p == N_PHASES - 1 ? $urandom : gains[p]);
      for (int n = 0; n < N_RANDOM / N_PHASES; n++) send_item(rand_item());
    end

    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    stim_done = 1'b1;
    repeat (PIPE_LAT + 10) @(posedge clk_i);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
rtl/core/hfcurv_pkg.sv
rtl/core/hfcurv_div.sv
rtl/core/axisymmetric_height_function_curvature_unit.sv
tb/axisymmetric_height_function_curvature_unit_test.sv
